// ===== design/datecv_pkg.sv =====
// Shared types, constants and the month length function for the calendar date unit.
`timescale 1ns / 1ps
package datecv_pkg;

  localparam int SECONDS_BITS = 34;
  localparam int NANO_W       = 30;
  localparam int YEAR_W       = 12;
  localparam int MONTH_W      = 4;
  localparam int DAY_W        = 5;
  localparam int HOUR_W       = 5;
  localparam int MINUTE_W     = 6;
  localparam int SECOND_W     = 6;

  localparam int IN_W        = SECONDS_BITS + NANO_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W + NANO_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_W;

  localparam int SPAN_W = 25;

  localparam logic [SPAN_W-1:0] SPAN_MINUTE = SPAN_W'(60);
  localparam logic [SPAN_W-1:0] SPAN_HOUR   = SPAN_W'(3600);
  localparam logic [SPAN_W-1:0] SPAN_DAY    = SPAN_W'(86400);
  localparam logic [SPAN_W-1:0] SPAN_28D    = SPAN_W'(28 * 86400);
  localparam logic [SPAN_W-1:0] SPAN_29D    = SPAN_W'(29 * 86400);
  localparam logic [SPAN_W-1:0] SPAN_30D    = SPAN_W'(30 * 86400);
  localparam logic [SPAN_W-1:0] SPAN_31D    = SPAN_W'(31 * 86400);
  localparam logic [SPAN_W-1:0] SPAN_COMMON = SPAN_W'(365 * 86400);
  localparam logic [SPAN_W-1:0] SPAN_LEAP   = SPAN_W'(366 * 86400);

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = YEAR_W'(1970);
  localparam logic [1:0]        EPOCH_MOD4   = 2'd2;
  localparam logic [6:0]        EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]        EPOCH_MOD400 = 9'd370;
  localparam logic [6:0]        MOD100_LAST  = 7'd99;
  localparam logic [8:0]        MOD400_LAST  = 9'd399;

  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(5);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(8);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(10);

  typedef struct packed {
    logic load;
    logic step;
  } sub_ctrl_t;

  typedef struct packed {
    logic init;
    logic advance;
  } leap_ctrl_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [NANO_W-1:0]    nanoseconds_out;
    logic [SECOND_W-1:0]  second_of_minute;
    logic [MINUTE_W-1:0]  minute;
    logic [HOUR_W-1:0]    hour;
    logic [DAY_W-1:0]     day_of_month;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
  } out_item_t;

  // Length in seconds of month m (0 is January).
  function automatic logic [SPAN_W-1:0] month_span(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
    logic [SPAN_W-1:0] span;
    span = SPAN_31D;
    if (m == MONTH_FEB) begin
      span = leap ? SPAN_29D : SPAN_28D;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      span = SPAN_30D;
    end
    return span;
  endfunction

endpackage

// ===== design/datecv_sub.sv =====
// Shared compare-and-subtract unit holding the remaining seconds.
`timescale 1ns / 1ps
module datecv_sub (
  input  logic                                clk,
  input  datecv_pkg::sub_ctrl_t               ctrl,
  input  logic [datecv_pkg::SECONDS_BITS-1:0] load_value,
  input  logic [datecv_pkg::SPAN_W-1:0]       span,
  output logic                                ge,
  output logic [datecv_pkg::SECONDS_BITS-1:0] rem
);

  logic [datecv_pkg::SECONDS_BITS-1:0] span_ext;

  assign span_ext = datecv_pkg::SECONDS_BITS'(span);
  assign ge       = (rem >= span_ext);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= load_value;
    end else if (ctrl.step) begin
      rem <= rem - span_ext;
    end
  end

endmodule

// ===== design/datecv_leap.sv =====
// Leap year tracker: year residues mod 4, 100 and 400 advanced with the year count.
`timescale 1ns / 1ps
module datecv_leap (
  input  logic                   clk,
  input  datecv_pkg::leap_ctrl_t ctrl,
  output logic                   leap
);

  logic [1:0] mod4;
  logic [6:0] mod100;
  logic [8:0] mod400;

  assign leap = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      mod4   <= datecv_pkg::EPOCH_MOD4;
      mod100 <= datecv_pkg::EPOCH_MOD100;
      mod400 <= datecv_pkg::EPOCH_MOD400;
    end else if (ctrl.advance) begin
      mod4   <= mod4 + 2'd1;
      mod100 <= (mod100 == datecv_pkg::MOD100_LAST) ? 7'd0 : mod100 + 7'd1;
      mod400 <= (mod400 == datecv_pkg::MOD400_LAST) ? 9'd0 : mod400 + 9'd1;
    end
  end

endmodule

// ===== design/epoch_seconds_to_calendar_date_unit.sv =====
// Top level: sequencer that converts epoch seconds to a UTC calendar date and time.
//
// Input stream (s_*): one transfer carries epoch_seconds and nanoseconds_in.
// Output stream (m_*): one transfer per input carries year, month, day_of_month,
// hour, minute, second_of_minute and nanoseconds_out.
// Sequence: the one compare-and-subtract unit takes off each whole year in turn
// (544 at most with 34-bit seconds), then up to 11 month steps, 30 day steps,
// 23 hour steps and 59 minute steps; each of those five phases ends with one
// compare that does not subtract, and ST_DONE then writes the result into the
// output register.
// Throughput: one item at a time; s_tready is high only while the sequencer is
// idle, which it is again in the cycle after the hand-over.
// The result sits in an output register, so a new item is taken while an old
// result still waits. When the receiver stalls and the next result is finished,
// the sequencer holds it until the register frees.
// Reset (rst, synchronous) returns the sequencer to idle and drops m_tvalid.
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_date_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // epoch_seconds, nanoseconds_in (from bit 0 up)
  input  logic [datecv_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // year, month, day_of_month, hour, minute, second_of_minute, nanoseconds_out
  output logic [datecv_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_YEAR  = 3'd1;
  localparam logic [2:0] ST_MONTH = 3'd2;
  localparam logic [2:0] ST_DAY   = 3'd3;
  localparam logic [2:0] ST_HOUR  = 3'd4;
  localparam logic [2:0] ST_MIN   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [datecv_pkg::YEAR_W-1:0]   year;
  logic [datecv_pkg::MONTH_W-1:0]  month;
  logic [datecv_pkg::DAY_W-1:0]    day;
  logic [datecv_pkg::HOUR_W-1:0]   hour;
  logic [datecv_pkg::MINUTE_W-1:0] minute;
  logic [datecv_pkg::NANO_W-1:0]   nanos;

  logic                                accept;
  logic                                out_free;
  logic                                ge;
  logic                                leap;
  logic [datecv_pkg::SPAN_W-1:0]       span;
  logic [datecv_pkg::SECONDS_BITS-1:0] rem;
  datecv_pkg::sub_ctrl_t               sub_ctrl;
  datecv_pkg::leap_ctrl_t              leap_ctrl;
  datecv_pkg::out_item_t               out_item;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (state)
      ST_YEAR:  span = leap ? datecv_pkg::SPAN_LEAP : datecv_pkg::SPAN_COMMON;
      ST_MONTH: span = datecv_pkg::month_span(leap, month);
      ST_DAY:   span = datecv_pkg::SPAN_DAY;
      ST_HOUR:  span = datecv_pkg::SPAN_HOUR;
      default:  span = datecv_pkg::SPAN_MINUTE;
    endcase
  end

  always_comb begin
    state_next        = state;
    sub_ctrl.load     = accept;
    sub_ctrl.step     = 1'b0;
    leap_ctrl.init    = accept;
    leap_ctrl.advance = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_YEAR;
        end
      end
      ST_YEAR: begin
        sub_ctrl.step     = ge;
        leap_ctrl.advance = ge;
        if (!ge) begin
          state_next = ST_MONTH;
        end
      end
      ST_MONTH: begin
        // December takes whatever is left
        sub_ctrl.step = ge && (month != datecv_pkg::MONTH_DEC);
        if (!sub_ctrl.step) begin
          state_next = ST_DAY;
        end
      end
      ST_DAY: begin
        sub_ctrl.step = ge;
        if (!ge) begin
          state_next = ST_HOUR;
        end
      end
      ST_HOUR: begin
        sub_ctrl.step = ge;
        if (!ge) begin
          state_next = ST_MIN;
        end
      end
      ST_MIN: begin
        sub_ctrl.step = ge;
        if (!ge) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Field counters: loaded on accept, bumped on each subtraction of their phase
  always_ff @(posedge clk) begin
    if (accept) begin
      year   <= datecv_pkg::EPOCH_YEAR;
      month  <= '0;
      day    <= '0;
      hour   <= '0;
      minute <= '0;
      nanos  <= s_tdata[datecv_pkg::IN_W-1:datecv_pkg::SECONDS_BITS];
    end else if (sub_ctrl.step) begin
      case (state)
        ST_YEAR:  year   <= year + datecv_pkg::YEAR_W'(1);
        ST_MONTH: month  <= month + datecv_pkg::MONTH_W'(1);
        ST_DAY:   day    <= day + datecv_pkg::DAY_W'(1);
        ST_HOUR:  hour   <= hour + datecv_pkg::HOUR_W'(1);
        ST_MIN:   minute <= minute + datecv_pkg::MINUTE_W'(1);
        default:  year   <= year;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    out_item                  = '0;
    out_item.year             = year;
    out_item.month            = month + datecv_pkg::MONTH_W'(1);
    out_item.day_of_month     = day + datecv_pkg::DAY_W'(1);
    out_item.hour             = hour;
    out_item.minute           = minute;
    out_item.second_of_minute = rem[datecv_pkg::SECOND_W-1:0];
    out_item.nanoseconds_out  = nanos;
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= out_item;
    end
  end

  datecv_sub u_sub (
    .clk        (clk),
    .ctrl       (sub_ctrl),
    .load_value (s_tdata[datecv_pkg::SECONDS_BITS-1:0]),
    .span       (span),
    .ge         (ge),
    .rem        (rem)
  );

  datecv_leap u_leap (
    .clk  (clk),
    .ctrl (leap_ctrl),
    .leap (leap)
  );

endmodule

// ===== design/datecv_checker.sv =====
// Port checker for the calendar date unit, bound to the top level.
`timescale 1ns / 1ps
module datecv_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [datecv_pkg::OUT_TDATA_W-1:0] m_tdata
);

  datecv_pkg::out_item_t item;

  assign item = m_tdata;

  // A waiting result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // One item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while conversion in progress");

  a_date: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> item.month >= 4'd1 && item.month <= 4'd12 && item.day_of_month != 5'd0)
    else $error("month or day out of range");

  a_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> item.hour <= 5'd23 && item.minute <= 6'd59 && item.second_of_minute <= 6'd59)
    else $error("time of day out of range");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

endmodule

bind epoch_seconds_to_calendar_date_unit datecv_checker u_datecv_checker (.*);
